[rtl/pte_pkg.sv]
// pte_pkg: shared widths, register indexes and the stage record for the
// polynomial trajectory evaluator
// no dependencies
package pte_pkg;

    // field widths
    localparam int TW    = 24;   // time, unsigned q8.16
    localparam int VW    = 48;   // coefficients and results, signed q24.24
    localparam int FRAC  = 16;   // fraction bits of time
    localparam int DW    = 53;   // weighted coefficient, up to 20 * coeff
    localparam int NLANE = 3;    // position, velocity, acceleration

    localparam int DEF_NUM_COEFFS = 6;

    // per-step arithmetic widths
    localparam int HI_W = VW - TW;                 // upper magnitude slice
    localparam int PH_W = HI_W + TW;               // upper partial product
    localparam int PL_W = 2 * TW;                  // lower partial product
    localparam int QW   = PH_W + (TW - FRAC) + 1;  // scaled magnitude
    localparam int SW   = QW + 2;                  // signed sum with coefficient

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VW;

    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_END_TIME   = CFG_IDX_W'(1);
    localparam int                   REG_COEFF_BASE = 2;

    // lane order inside a stage record
    localparam int LANE_POS = 0;
    localparam int LANE_VEL = 1;
    localparam int LANE_ACC = 2;

    // one request travelling down the chain of cells
    typedef struct packed {
        logic                      valid;
        logic                      in_range;
        logic [TW-1:0]             t;
        logic [NLANE-1:0][VW-1:0]  val;
    } pte_stage_t;

    typedef logic [NLANE-1:0][DW-1:0] pte_weight_t;

endpackage

[rtl/pte_coeff_bank.sv]
// pte_coeff_bank: configuration registers and the derivative-weighted
// coefficients for every horner step
// depends on pte_pkg
module pte_coeff_bank
    import pte_pkg::*;
#(
    parameter int NUM_COEFFS = DEF_NUM_COEFFS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output logic [TW-1:0]               start_time,
    output logic [TW-1:0]               end_time,
    output pte_weight_t [NUM_COEFFS-1:0] weights
);

    logic [TW-1:0]         start_time_reg;
    logic [TW-1:0]         end_time_reg;
    logic signed [VW-1:0]  coeff_reg [NUM_COEFFS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            end_time_reg   <= '0;
            for (int j = 0; j < NUM_COEFFS; j++)
            begin
                coeff_reg[j] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_START_TIME)
            begin
                start_time_reg <= cfg_data[TW-1:0];
            end
            if (cfg_index == REG_END_TIME)
            begin
                end_time_reg <= cfg_data[TW-1:0];
            end
            // coefficients above the polynomial order are dropped
            for (int j = 0; j < NUM_COEFFS; j++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_COEFF_BASE + j))
                begin
                    coeff_reg[j] <= cfg_data;
                end
            end
        end
    end

    assign start_time = start_time_reg;
    assign end_time   = end_time_reg;

    // weighted coefficients for horner step k
    for (genvar k = 0; k < NUM_COEFFS; k++)
    begin : g_weight
        logic signed [DW-1:0] pos_next, vel_next, acc_next;
        logic signed [DW-1:0] pos_reg, vel_reg, acc_reg;

        assign pos_next = DW'(coeff_reg[k]);

        if (k + 1 < NUM_COEFFS)
        begin : g_vel
            assign vel_next = DW'(coeff_reg[k+1]) * DW'(k + 1);
        end
        else
        begin : g_vel_zero
            assign vel_next = '0;
        end

        if (k + 2 < NUM_COEFFS)
        begin : g_acc
            assign acc_next = DW'(coeff_reg[k+2]) * DW'((k + 1) * (k + 2));
        end
        else
        begin : g_acc_zero
            assign acc_next = '0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pos_reg <= '0;
                vel_reg <= '0;
                acc_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                vel_reg <= vel_next;
                acc_reg <= acc_next;
            end
        end

        assign weights[k][LANE_POS] = pos_reg;
        assign weights[k][LANE_VEL] = vel_reg;
        assign weights[k][LANE_ACC] = acc_reg;
    end

endmodule

[rtl/pte_cell.sv]
// pte_cell: one horner step for all three lanes, acc = sat(round(acc * t) + d),
// split over a product stage and a round/add/saturate stage
// depends on pte_pkg
module pte_cell
    import pte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  pte_stage_t  up,
    input  pte_weight_t d,
    output pte_stage_t  down
);

    // product stage
    logic                    s1_valid_reg, s1_in_range_reg;
    logic [TW-1:0]           s1_t_reg;
    logic [NLANE-1:0]        s1_neg_reg, s1_neg_next;
    logic [NLANE-1:0][PH_W-1:0] s1_hi_reg, s1_hi_next;
    logic [NLANE-1:0][PL_W-1:0] s1_lo_reg, s1_lo_next;

    always_comb
    begin
        logic [VW-1:0] mag;
        for (int l = 0; l < NLANE; l++)
        begin
            s1_neg_next[l] = up.val[l][VW-1];
            mag            = s1_neg_next[l] ? (~up.val[l] + VW'(1)) : up.val[l];
            s1_hi_next[l]  = PH_W'(mag[VW-1:TW]) * PH_W'(up.t);
            s1_lo_next[l]  = PL_W'(mag[TW-1:0]) * PL_W'(up.t);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_in_range_reg <= 1'b0;
            s1_t_reg        <= '0;
            s1_neg_reg      <= '0;
            s1_hi_reg       <= '0;
            s1_lo_reg       <= '0;
        end
        else if (en)
        begin
            s1_valid_reg    <= up.valid;
            s1_in_range_reg <= up.in_range;
            s1_t_reg        <= up.t;
            s1_neg_reg      <= s1_neg_next;
            s1_hi_reg       <= s1_hi_next;
            s1_lo_reg       <= s1_lo_next;
        end
    end

    // round, restore sign, add weighted coefficient, saturate
    pte_stage_t down_reg, down_next;

    always_comb
    begin
        logic [PL_W:0]         lo_rnd;
        logic [QW-1:0]         q;
        logic signed [SW-1:0]  sq;
        logic signed [SW-1:0]  sum;
        down_next          = down_reg;
        down_next.valid    = s1_valid_reg;
        down_next.in_range = s1_in_range_reg;
        down_next.t        = s1_t_reg;
        for (int l = 0; l < NLANE; l++)
        begin
            lo_rnd = (PL_W+1)'(s1_lo_reg[l]) + (PL_W+1)'(1 << (FRAC - 1));
            q      = QW'({s1_hi_reg[l], {(TW-FRAC){1'b0}}}) + QW'(lo_rnd >> FRAC);
            sq     = s1_neg_reg[l] ? -$signed(SW'(q)) : $signed(SW'(q));
            sum    = sq + SW'($signed(d[l]));
            if (sum[SW-1:VW-1] == '0 || sum[SW-1:VW-1] == '1)
            begin
                down_next.val[l] = sum[VW-1:0];
            end
            else if (sum[SW-1])
            begin
                down_next.val[l] = {1'b1, {(VW-1){1'b0}}};
            end
            else
            begin
                down_next.val[l] = {1'b0, {(VW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg <= '0;
        end
        else if (en)
        begin
            down_reg <= down_next;
        end
    end

    assign down = down_reg;

endmodule

[rtl/polynomial_trajectory_evaluator.sv]
// polynomial_trajectory_evaluator: top level, window check, chain of horner
// cells and output register
// depends on pte_pkg, pte_coeff_bank, pte_cell
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   cfg      | cfg_write (no wait)       | cfg_index, cfg_data
//   in       | in_valid / in_ready       | sample_time
//   out      | out_valid / out_ready     | in_range, position, velocity, acceleration
//
// one request enters per cycle unless a stalled result freezes the chain; each
// horner cell registers partial products, then round/add/saturate, before the output register
// reset clears configuration to zero and empties the chain
// a result held at the output with out_ready low freezes the whole chain and
// drops in_ready in the same cycle
module polynomial_trajectory_evaluator
    import pte_pkg::*;
#(
    parameter int NUM_COEFFS = DEF_NUM_COEFFS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration writes
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // sample requests
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [TW-1:0]           sample_time,
    // results
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    in_range,
    output logic signed [VW-1:0]    position,
    output logic signed [VW-1:0]    velocity,
    output logic signed [VW-1:0]    acceleration
);

    logic [TW-1:0]                  start_time;
    logic [TW-1:0]                  end_time;
    pte_weight_t [NUM_COEFFS-1:0]   weights;

    // output register, out-of-window samples give zeros
    logic                  out_valid_reg;
    logic                  in_range_reg;
    logic signed [VW-1:0]  position_reg, velocity_reg, acceleration_reg;
    pte_stage_t            last;

    pte_coeff_bank #(
        .NUM_COEFFS (NUM_COEFFS)
    ) u_coeff_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start_time (start_time),
        .end_time   (end_time),
        .weights    (weights)
    );

    // the whole chain moves together unless a finished result is stuck
    logic advance;
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // request entering the first cell, accumulators start at zero
    pte_stage_t stage [NUM_COEFFS+1];

    always_comb
    begin
        stage[0]          = '0;
        stage[0].valid    = in_valid && advance;
        stage[0].t        = sample_time;
        // an inverted window holds no time at all
        stage[0].in_range = (sample_time >= start_time) && (sample_time <= end_time);
    end

    // cell i applies the coefficient of power NUM_COEFFS-1-i, highest first
    for (genvar i = 0; i < NUM_COEFFS; i++)
    begin : g_cell
        pte_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (advance),
            .up    (stage[i]),
            .d     (weights[NUM_COEFFS-1-i]),
            .down  (stage[i+1])
        );
    end

    assign last = stage[NUM_COEFFS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            in_range_reg     <= 1'b0;
            position_reg     <= '0;
            velocity_reg     <= '0;
            acceleration_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= last.valid;
            if (last.valid)
            begin
                in_range_reg     <= last.in_range;
                position_reg     <= last.in_range ? last.val[LANE_POS] : '0;
                velocity_reg     <= last.in_range ? last.val[LANE_VEL] : '0;
                acceleration_reg <= last.in_range ? last.val[LANE_ACC] : '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign in_range     = in_range_reg;
    assign position     = position_reg;
    assign velocity     = velocity_reg;
    assign acceleration = acceleration_reg;

endmodule

[rtl/pte_checker.sv]
// pte_checker: port-level assertions for the polynomial trajectory evaluator,
// bound to the top level
// depends on pte_pkg
module pte_checker
    import pte_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    in_range,
    input logic signed [VW-1:0]    position,
    input logic signed [VW-1:0]    velocity,
    input logic signed [VW-1:0]    acceleration
);

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position)
            && $stable(velocity) && $stable(acceleration) && $stable(in_range))
    else $error("stalled result changed");

    // out-of-window samples report zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> position == '0 && velocity == '0 && acceleration == '0)
    else $error("out-of-window result not zero");

    // a stuck result holds back new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("request taken while chain is frozen");

    // the chain never blocks while the consumer takes results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
    else $error("in_ready low with out_ready high");

endmodule

bind polynomial_trajectory_evaluator pte_checker u_pte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .in_range     (in_range),
    .position     (position),
    .velocity     (velocity),
    .acceleration (acceleration)
);
